FILE: design/wnps_pkg.sv
package wnps_pkg;

  // store depth and derived widths
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 18;
  localparam int OUT_IDX_W = 10;
  localparam int FUNC_W    = 2;

  // arithmetic widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int DIST_W = SQ_W + 1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(2560);

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // chain control: shift moves every cell one step toward the head,
  // rotate feeds the head back into the tail instead of the new point
  typedef struct packed {
    logic shift;
    logic rotate;
  } chain_ctl_t;

  // one scanned point entering the distance pipeline
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } sample_t;

  // status of the distance pipeline
  typedef struct packed {
    logic             busy;
    logic             have;
    logic [IDX_W-1:0] idx;
  } eval_stat_t;

endpackage

FILE: design/wnps_cell.sv
module wnps_cell (
  input  logic            clk,
  input  logic            shift,
  input  wnps_pkg::point_t pt_in,
  output wnps_pkg::point_t pt_out
);

  wnps_pkg::point_t pt_r;

  // take the neighbor's point on a shift
  always_ff @(posedge clk) begin
    if (shift) begin
      pt_r <= pt_in;
    end
  end

  assign pt_out = pt_r;

endmodule

FILE: design/wnps_chain.sv
module wnps_chain (
  input  logic                clk,
  input  wnps_pkg::chain_ctl_t ctl,
  input  wnps_pkg::point_t     new_pt,
  output wnps_pkg::point_t     head_pt
);

  wnps_pkg::point_t cell_q [wnps_pkg::MAX_POINTS];
  wnps_pkg::point_t tail_in;

  // tail takes the new point on append, the head point on rotate
  assign tail_in = ctl.rotate ? cell_q[0] : new_pt;

  for (genvar i = 0; i < wnps_pkg::MAX_POINTS; i++) begin : g_cell
    if (i == wnps_pkg::MAX_POINTS - 1) begin : g_tail
      wnps_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .pt_in  (tail_in),
        .pt_out (cell_q[i])
      );
    end else begin : g_body
      wnps_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .pt_in  (cell_q[i+1]),
        .pt_out (cell_q[i])
      );
    end
  end

  assign head_pt = cell_q[0];

endmodule

FILE: design/wnps_eval.sv
module wnps_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear_best,
  input  wnps_pkg::sample_t             smp,
  input  wnps_pkg::point_t              qpt,
  input  logic [wnps_pkg::RAD_W-1:0]    radius,
  output wnps_pkg::eval_stat_t          stat
);

  // stage 1: coordinate differences
  logic                               s1_v_r;
  logic [wnps_pkg::IDX_W-1:0]         s1_idx_r;
  logic signed [wnps_pkg::DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;

  // stage 2: window test and magnitudes
  logic                               s2_v_r;
  logic [wnps_pkg::IDX_W-1:0]         s2_idx_r;
  logic [wnps_pkg::RAD_W-1:0]         mx_r, my_r;
  logic [wnps_pkg::DIFF_W-1:0]        adx, ady;
  logic                               inwin;

  // stage 3: squares
  logic                               s3_v_r;
  logic [wnps_pkg::IDX_W-1:0]         s3_idx_r;
  logic [wnps_pkg::SQ_W-1:0]          sqx_r, sqy_r;

  // running best
  logic                               have_r;
  logic [wnps_pkg::IDX_W-1:0]         best_idx_r;
  logic [wnps_pkg::DIST_W-1:0]        dbest_r, dist_sum;
  logic                               take;

  assign dx_nxt = wnps_pkg::DIFF_W'($signed(smp.pt.x)) - wnps_pkg::DIFF_W'($signed(qpt.x));
  assign dy_nxt = wnps_pkg::DIFF_W'($signed(smp.pt.y)) - wnps_pkg::DIFF_W'($signed(qpt.y));

  assign adx   = dx_r[wnps_pkg::DIFF_W-1] ? wnps_pkg::DIFF_W'(-dx_r) : wnps_pkg::DIFF_W'(dx_r);
  assign ady   = dy_r[wnps_pkg::DIFF_W-1] ? wnps_pkg::DIFF_W'(-dy_r) : wnps_pkg::DIFF_W'(dy_r);
  assign inwin = (adx < wnps_pkg::DIFF_W'(radius)) && (ady < wnps_pkg::DIFF_W'(radius));

  assign dist_sum = wnps_pkg::DIST_W'(sqx_r) + wnps_pkg::DIST_W'(sqy_r);
  assign take     = s3_v_r && (!have_r || (dist_sum < dbest_r));

  // stage valids and best flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      s1_v_r <= smp.vld;
      s2_v_r <= s1_v_r && inwin;
      s3_v_r <= s2_v_r;
      if (clear_best) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    s1_idx_r <= smp.idx;
    mx_r     <= adx[wnps_pkg::RAD_W-1:0];
    my_r     <= ady[wnps_pkg::RAD_W-1:0];
    s2_idx_r <= s1_idx_r;
    sqx_r    <= wnps_pkg::SQ_W'(mx_r) * wnps_pkg::SQ_W'(mx_r);
    sqy_r    <= wnps_pkg::SQ_W'(my_r) * wnps_pkg::SQ_W'(my_r);
    s3_idx_r <= s2_idx_r;
    if (take) begin
      dbest_r    <= dist_sum;
      best_idx_r <= s3_idx_r;
    end
  end

  assign stat.busy = s1_v_r || s2_v_r || s3_v_r;
  assign stat.have = have_r;
  assign stat.idx  = best_idx_r;

endmodule

FILE: design/windowed_nearest_point_search.sv
// query: accepted, then the point chain rotates once past the head (ST_SCAN),
//   the distance pipeline drains (ST_DRAIN), then the result registers once the output is free
// clear and append: accepted while idle, no result; one transaction in work at a time
// every query scans through the single distance unit; no new transaction is taken until its result registers
// reset clears the point count, the radius (to 2560) and the sequencer and valid flags;
//   stored point contents are left as they are and no clearing pass runs
module windowed_nearest_point_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [wnps_pkg::RAD_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wnps_pkg::FUNC_W-1:0]     in_func,
  input  logic signed [wnps_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [wnps_pkg::COORD_W-1:0] in_y_coord,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [wnps_pkg::OUT_IDX_W-1:0]  out_point_index
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t                         state_r;
  logic                           out_valid_r;
  logic                           out_found_r;
  logic [wnps_pkg::OUT_IDX_W-1:0] out_idx_r;

  logic [wnps_pkg::RAD_W-1:0]     radius_r;
  logic [wnps_pkg::CNT_W-1:0]     count_r;
  logic [wnps_pkg::IDX_W-1:0]     scan_r;
  wnps_pkg::point_t               qpt_r;

  logic                           in_acc;
  logic                           is_query, is_append, is_clear;
  logic                           scan_last;
  logic                           out_free;
  logic                           res_load;
  logic [wnps_pkg::CNT_W-1:0]     start;
  wnps_pkg::point_t               in_pt, head_pt;
  wnps_pkg::chain_ctl_t           ctl;
  wnps_pkg::sample_t              smp;
  wnps_pkg::eval_stat_t           stat;

  // input transaction decode
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_clear  = in_acc && (in_func == wnps_pkg::FUNC_CLEAR);
  assign is_append = in_acc && (in_func == wnps_pkg::FUNC_APPEND);
  assign is_query  = in_acc && (in_func == wnps_pkg::FUNC_QUERY);
  assign in_pt.x   = in_x_coord;
  assign in_pt.y   = in_y_coord;

  // chain control: append shifts in at the tail while the store is not full, a scan rotates the ring
  assign ctl.rotate = (state_r == ST_SCAN);
  assign ctl.shift  = ctl.rotate ||
                      (is_append && (count_r < wnps_pkg::CNT_W'(wnps_pkg::MAX_POINTS)));

  // points sit in the top count cells, oldest nearest the head
  assign start     = wnps_pkg::CNT_W'(wnps_pkg::MAX_POINTS) - count_r;
  assign scan_last = (scan_r == wnps_pkg::IDX_W'(wnps_pkg::MAX_POINTS - 1));
  assign smp.vld   = (state_r == ST_SCAN) && ({1'b0, scan_r} >= start);
  assign smp.idx   = scan_r - start[wnps_pkg::IDX_W-1:0];
  assign smp.pt    = head_pt;

  assign out_free  = !out_valid_r || !out_stall;
  assign res_load  = (state_r == ST_DRAIN) && !stat.busy && out_free;

  wnps_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .new_pt  (in_pt),
    .head_pt (head_pt)
  );

  wnps_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_best (is_query),
    .smp        (smp),
    .qpt        (qpt_r),
    .radius     (radius_r),
    .stat       (stat)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (is_query) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res_load) begin
            out_found_r <= stat.have;
            out_idx_r   <= stat.have ? wnps_pkg::OUT_IDX_W'(stat.idx) : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // radius register and point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= wnps_pkg::RADIUS_RESET;
      count_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (is_clear) begin
        count_r <= '0;
      end else if (is_append && (count_r < wnps_pkg::CNT_W'(wnps_pkg::MAX_POINTS))) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // query point and scan position
  always_ff @(posedge clk) begin
    if (is_query) begin
      qpt_r  <= in_pt;
      scan_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_point_index = out_idx_r;

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [wnps_pkg::COORD_W-1:0] coord_t;
  typedef logic [wnps_pkg::FUNC_W-1:0]         func_t;
  typedef logic [wnps_pkg::OUT_IDX_W-1:0]      oidx_t;
  typedef logic [wnps_pkg::RAD_W-1:0]          rad_t;

  // one query answer as the block reports it
  typedef struct packed {
    logic  found;
    oidx_t idx;
  } query_answer_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    func_t  func;
    coord_t x;
    coord_t y;
    logic   typed;
    logic   found;
    oidx_t  idx;
  } stim_row_t;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam func_t F_CLR       = wnps_pkg::FUNC_CLEAR;
  localparam func_t F_APP       = wnps_pkg::FUNC_APPEND;
  localparam func_t F_QRY       = wnps_pkg::FUNC_QUERY;
  localparam rad_t  RAD_MAX     = {wnps_pkg::RAD_W{1'b1}};
  localparam int QUIET_CYCLES = 8;
  localparam int TAIL_CYCLES  = wnps_pkg::MAX_POINTS + 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int N_DIRECTED   = 24;

  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // empty store, then an unused code at the coordinate extremes
    '{F_QRY,       24'h000000, 24'h000000, 1'b1, 1'b0, 10'd0},
    '{FUNC_UNUSED, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 10'd0},
    // origin and the two far corners
    '{F_APP,       24'h000000, 24'h000000, 1'b0, 1'b0, 10'd0},
    '{F_APP,       24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 10'd0},
    '{F_APP,       24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 10'd0},
    '{F_QRY,       24'h000000, 24'h000000, 1'b1, 1'b1, 10'd0},
    '{F_QRY,       24'h7FFFFF, 24'h800000, 1'b1, 1'b1, 10'd1},
    '{F_QRY,       24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 10'd2},
    // window edge is exclusive, one lsb inside is found
    '{F_QRY,       24'sd2560,  24'sd0,     1'b1, 1'b0, 10'd0},
    '{F_QRY,       24'sd0,     -24'sd2560, 1'b1, 1'b0, 10'd0},
    '{F_QRY,       24'sd2559,  -24'sd2559, 1'b1, 1'b1, 10'd0},
    // duplicate point, lowest index wins
    '{F_APP,       24'sd0,     24'sd0,     1'b0, 1'b0, 10'd0},
    '{F_QRY,       24'sd0,     24'sd0,     1'b1, 1'b1, 10'd0},
    '{F_APP,       24'sd100,   24'sd100,   1'b0, 1'b0, 10'd0},
    '{F_QRY,       24'sd60,    24'sd60,    1'b0, 1'b0, 10'd0},
    // equal distance to two points
    '{F_QRY,       24'sd50,    24'sd50,    1'b1, 1'b1, 10'd0},
    '{F_QRY,       24'h7FFFF0, 24'h800010, 1'b0, 1'b0, 10'd0},
    // clear empties the store
    '{F_CLR,       24'sd0,     24'sd0,     1'b0, 1'b0, 10'd0},
    '{F_QRY,       24'sd0,     24'sd0,     1'b1, 1'b0, 10'd0},
    '{F_APP,       -24'sd1,    -24'sd1,    1'b0, 1'b0, 10'd0},
    '{F_APP,       24'sd2558,  24'sd2558,  1'b0, 1'b0, 10'd0},
    '{F_QRY,       24'sd1279,  24'sd1279,  1'b0, 1'b0, 10'd0},
    '{F_QRY,       -24'sd2560, -24'sd2560, 1'b0, 1'b0, 10'd0},
    '{FUNC_UNUSED, 24'sd0,     24'sd0,     1'b0, 1'b0, 10'd0}
  };

  // dut signals
  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_wr_en;
  rad_t   cfg_wr_data;
  logic   in_valid;
  logic   in_stall;
  func_t  in_func;
  coord_t in_x_coord;
  coord_t in_y_coord;
  logic   out_valid;
  logic   out_stall;
  logic   out_found;
  oidx_t  out_point_index;

  // predictor state
  coord_t store_x [wnps_pkg::MAX_POINTS];
  coord_t store_y [wnps_pkg::MAX_POINTS];
  int     store_count;
  rad_t   radius_now;

  query_answer_t pending_answers [$];
  int mismatches     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;

  always #2 clk = ~clk;

  windowed_nearest_point_search i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_point_index (out_point_index)
  );

  // nearest stored point strictly inside the square window
  function automatic query_answer_t nearest_in_window(input coord_t qx, input coord_t qy);
    query_answer_t ans;
    longint r, dx, dy, d, dmin;
    int best;
    bit hit;
    ans  = '0;
    r    = longint'(radius_now);
    hit  = 1'b0;
    best = 0;
    dmin = 0;
    for (int j = 0; j < store_count; j++) begin
      dx = longint'(store_x[j]) - longint'(qx);
      dy = longint'(store_y[j]) - longint'(qy);
      if (dx > -r && dx < r && dy > -r && dy < r) begin
        d = dx * dx + dy * dy;
        if (!hit || d < dmin) begin
          hit  = 1'b1;
          dmin = d;
          best = j;
        end
      end
    end
    ans.found = hit;
    ans.idx   = hit ? wnps_pkg::OUT_IDX_W'(best) : '0;
    return ans;
  endfunction

  // update the store for one accepted transaction
  function automatic void apply_to_store(input func_t f, input coord_t x,
                                         input coord_t y, output bit has_ans,
                                         output query_answer_t ans);
    has_ans = 1'b0;
    ans     = '0;
    case (f)
      F_CLR: store_count = 0;
      F_APP: begin
        if (store_count < wnps_pkg::MAX_POINTS) begin
          store_x[store_count] = x;
          store_y[store_count] = y;
          store_count++;
        end
      end
      F_QRY: begin
        has_ans = 1'b1;
        ans     = nearest_in_window(x, y);
      end
      default: ;
    endcase
  endfunction

  function automatic coord_t near_to(input coord_t c, input int span);
    return coord_t'(int'(c) + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 40)
      $display("cycle %0d: %s mismatch, got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // offer one transaction, wait for acceptance, record the expected answer
  task automatic push_op(input func_t f, input coord_t x, input coord_t y,
                         input bit typed = 1'b0, input logic t_found = 1'b0,
                         input oidx_t t_idx = '0);
    bit has_ans;
    query_answer_t ans;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (in_stall);
    apply_to_store(f, x, y, has_ans, ans);
    if (typed) begin
      ans.found = t_found;
      ans.idx   = t_idx;
    end
    if (has_ans) pending_answers.push_back(ans);
  endtask

  // stop offering until every pending answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_radius(input rad_t r);
    drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    radius_now = r;
  endtask

  // a cluster of points around a center and queries into it, or noise
  task automatic random_scene(output int n_done);
    coord_t cx, cy, lx, ly;
    func_t f;
    int span, n_pts, n_qry;
    n_done = 0;
    span   = int'(radius_now) + 16;
    cx     = coord_t'($urandom);
    cy     = coord_t'($urandom);
    if ($urandom_range(7) == 0) cx = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    if ($urandom_range(7) == 0) cy = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    lx = cx;
    ly = cy;
    if ($urandom_range(9) < 2) begin
      // noise: any code, anywhere
      repeat ($urandom_range(4, 1)) begin
        f = wnps_pkg::FUNC_W'($urandom);
        push_op(f, coord_t'($urandom), coord_t'($urandom));
        if (f != FUNC_UNUSED) n_done++;
      end
    end else begin
      if ($urandom_range(3) != 0) begin
        push_op(F_CLR, cx, cy);
        n_done++;
      end
      n_pts = $urandom_range(10, 1);
      for (int i = 0; i < n_pts; i++) begin
        // sometimes repeat the last point to force a tie
        if (i == 0 || $urandom_range(4) != 0) begin
          lx = near_to(cx, span);
          ly = near_to(cy, span);
        end
        push_op(F_APP, lx, ly);
        n_done++;
      end
      n_qry = $urandom_range(5, 1);
      repeat (n_qry) begin
        if ($urandom_range(5) == 0) push_op(F_QRY, lx, ly);
        else push_op(F_QRY, near_to(cx, span), near_to(cy, span));
        n_done++;
      end
    end
  endtask

  task automatic run_scenes(input int n_items);
    int sent, got;
    sent = 0;
    while (sent < n_items) begin
      random_scene(got);
      sent += got;
    end
  endtask

  // fill the store past its depth, then query the far entries
  task automatic fill_store();
    coord_t cx, cy;
    int span;
    cx   = coord_t'($urandom);
    cy   = coord_t'($urandom);
    span = int'(radius_now);
    push_op(F_CLR, cx, cy);
    repeat (wnps_pkg::MAX_POINTS + 6) push_op(F_APP, near_to(cx, span), near_to(cy, span));
    push_op(F_QRY, store_x[wnps_pkg::MAX_POINTS-1], store_y[wnps_pkg::MAX_POINTS-1]);
    push_op(F_QRY, store_x[wnps_pkg::MAX_POINTS/2], store_y[wnps_pkg::MAX_POINTS/2]);
    push_op(F_QRY, cx, cy);
    repeat (5) push_op(F_QRY, near_to(cx, span), near_to(cy, span));
  endtask

  // result side: check accepted transactions, stall at random or on request
  initial begin
    int hold_left;
    bit hold_seen;
    query_answer_t want;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result, found", out_found, 0);
        end else begin
          want = pending_answers.pop_front();
          if (out_found !== want.found) report_mismatch("found", out_found, want.found);
          if (out_point_index !== want.idx)
            report_mismatch("point_index", out_point_index, want.idx);
        end
      end
      if (hold_request > 0 && !hold_seen) begin
        hold_left = hold_request;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_func     = F_CLR;
    in_x_coord  = '0;
    in_y_coord  = '0;
    store_count = 0;
    radius_now  = wnps_pkg::RADIUS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset radius
    send_idle_pct = 11;
    recv_idle_pct = 68;
    foreach (DIRECTED[i])
      push_op(DIRECTED[i].func, DIRECTED[i].x, DIRECTED[i].y,
              DIRECTED[i].typed, DIRECTED[i].found, DIRECTED[i].idx);

    // zero radius, then a random one with a long receiver hold-off
    set_radius('0);
    run_scenes(40);
    set_radius(wnps_pkg::RAD_W'($urandom_range(8000, 1)));
    hold_request = HOLD_CYCLES;
    run_scenes(20);
    drain();
    run_scenes(100);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 68;
    recv_idle_pct = 11;
    set_radius(RAD_MAX);
    run_scenes(60);
    set_radius(wnps_pkg::RAD_W'(1));
    run_scenes(40);
    set_radius(wnps_pkg::RAD_W'($urandom));
    run_scenes(60);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_radius(wnps_pkg::RAD_W'($urandom_range(20000, 2)));
    run_scenes(100);
    set_radius(RAD_MAX);
    fill_store();

    // wait for the last answers and watch for strays
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wnps_pkg.sv
design/wnps_cell.sv
design/wnps_chain.sv
design/wnps_eval.sv
design/windowed_nearest_point_search.sv
verif/testbench.sv
